@@ src/sts_pkg.sv @@
package sts_pkg;

  localparam int unsigned MaxTokenLenDef = 128;
  localparam int unsigned FifoDepth      = 4;
  localparam int unsigned LineW          = 16;

  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSemi    = 8'h3B;
  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharQuote   = 8'h22;

  typedef enum logic [2:0] {
    ModeSeek    = 3'd0,
    ModeSlash   = 3'd1,
    ModeComment = 3'd2,
    ModePlain   = 3'd3,
    ModeQuoted  = 3'd4,
    ModeEnded   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ErrNone = 2'd0,
    ErrLine = 2'd1,
    ErrLong = 2'd2
  } err_e;

  typedef struct packed {
    mode_e            mode;
    logic [7:0]       len;
    logic [LineW-1:0] line;
  } state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       done;
    err_e       err;
  } item_t;

  localparam item_t ItemNone = '{ch: 8'h00, has: 1'b0, done: 1'b0, err: ErrNone};

  typedef struct packed {
    logic [7:0]       token_char;
    logic             has_char;
    logic             token_done;
    logic [LineW-1:0] line_number;
    logic             script_over;
    logic [1:0]       error_code;
    logic             last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

@@ src/sts_if.sv @@
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       final_byte;
  logic       same_line_only;

  modport source(output valid, output script_byte, output final_byte,
                 output same_line_only, input ready);
  modport sink(input valid, input script_byte, input final_byte,
               input same_line_only, output ready);
endinterface

interface sts_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  token_char;
  logic        has_char;
  logic        token_done;
  logic [15:0] line_number;
  logic        script_over;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source(output valid, output token_char, output has_char, output token_done,
                 output line_number, output script_over, output error_code,
                 output last_of_run, input ready);
  modport sink(input valid, input token_char, input has_char, input token_done,
               input line_number, input script_over, input error_code,
               input last_of_run, output ready);
endinterface

@@ src/sts_step.sv @@
module sts_step #(
  parameter int unsigned MaxTokenLen = sts_pkg::MaxTokenLenDef
) (
  input  sts_pkg::state_t state_i,
  input  logic [7:0]      script_byte_i,
  input  logic            final_byte_i,
  input  logic            same_line_only_i,
  output sts_pkg::state_t state_o,
  output sts_pkg::step_t  step_o
);
  import sts_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MaxTokenLen);

  typedef struct packed {
    item_t      it;
    logic       end_tok;
    logic [7:0] len;
  } add_t;

  typedef struct packed {
    logic       put;
    item_t      it;
    mode_e      mode;
    logic [7:0] len;
    logic       line_up;
    logic       ws_fin;
  } seek_t;

  function automatic add_t add_char(logic [7:0] len, logic [7:0] ch, logic fin);
    add_t       a;
    logic [7:0] nl;
    nl        = (len != 8'hFF) ? len + 8'd1 : len;
    a.it.ch   = ch;
    a.it.has  = 1'b1;
    a.it.done = fin;
    a.it.err  = ErrNone;
    a.end_tok = fin;
    a.len     = nl;
    if (!fin && nl >= MaxLen) begin
      a.it.done = 1'b1;
      a.it.err  = ErrLong;
      a.end_tok = 1'b1;
    end
    if (a.end_tok) begin
      a.len = '0;
    end
    return a;
  endfunction

  function automatic seek_t seek(logic [7:0] b, logic fin, logic sl);
    seek_t s;
    add_t  a;
    s.put     = 1'b0;
    s.it      = ItemNone;
    s.mode    = ModeSeek;
    s.len     = '0;
    s.line_up = 1'b0;
    s.ws_fin  = 1'b0;
    a         = add_char(8'd0, b, fin);
    if (b <= CharSpace) begin
      if (b == CharNewline) begin
        s.put     = sl;
        s.it.err  = ErrLine;
        s.line_up = 1'b1;
      end
      s.ws_fin = fin;
    end else if (b == CharSemi) begin
      s.mode   = ModeComment;
      s.put    = sl;
      s.it.err = ErrLine;
    end else if (b == CharSlash && !fin) begin
      s.mode = ModeSlash;
    end else begin
      s.put  = 1'b1;
      s.it   = a.it;
      s.len  = a.len;
      s.mode = a.end_tok ? ModeSeek : ((b == CharQuote) ? ModeQuoted : ModePlain);
    end
    return s;
  endfunction

  seek_t            sk;
  add_t             ad, ad_slash, ad_next;
  item_t            a_it, b_it, r0_it, r1_it, term_it;
  logic             a_v, b_v, line_up, ws_fin, plain_c, is_ended, over0, over1;
  logic             fill;
  logic [1:0]       n;
  mode_e            nmode;
  logic [7:0]       nlen;
  logic [LineW-1:0] nline;

  always_comb begin
    sk       = seek(script_byte_i, final_byte_i, same_line_only_i);
    ad       = add_char(state_i.len, script_byte_i, final_byte_i);
    ad_slash = add_char(8'd0, CharSlash, 1'b0);
    ad_next  = add_char(ad_slash.len, script_byte_i, final_byte_i);
    plain_c  = script_byte_i > CharSpace && script_byte_i != CharSemi &&
               script_byte_i != CharQuote;
    term_it      = ItemNone;
    term_it.done = 1'b1;

    a_v      = 1'b0;
    a_it     = ItemNone;
    b_v      = 1'b0;
    b_it     = ItemNone;
    nmode    = state_i.mode;
    nlen     = state_i.len;
    line_up  = 1'b0;
    ws_fin   = 1'b0;
    is_ended = 1'b0;

    unique case (state_i.mode)
      ModeEnded: begin
        is_ended = 1'b1;
      end
      ModeSlash: begin
        if (script_byte_i == CharSlash) begin
          nmode     = ModeComment;
          a_v       = same_line_only_i;
          a_it.err  = ErrLine;
        end else if (plain_c) begin
          a_v   = 1'b1;
          a_it  = ad_slash.it;
          b_v   = 1'b1;
          b_it  = ad_next.it;
          nmode = ad_next.end_tok ? ModeSeek : ModePlain;
          nlen  = ad_next.len;
        end else begin
          a_v     = 1'b1;
          a_it    = term_it;
          a_it.ch = CharSlash;
          a_it.has = 1'b1;
          b_v     = sk.put;
          b_it    = sk.it;
          nmode   = sk.mode;
          nlen    = sk.len;
          line_up = sk.line_up;
          ws_fin  = sk.ws_fin;
        end
      end
      ModeComment: begin
        if (script_byte_i == CharNewline) begin
          line_up = 1'b1;
          nmode   = ModeSeek;
        end
      end
      ModePlain: begin
        if (plain_c) begin
          a_v   = 1'b1;
          a_it  = ad.it;
          nmode = ad.end_tok ? ModeSeek : ModePlain;
          nlen  = ad.len;
        end else begin
          a_v     = 1'b1;
          a_it    = term_it;
          b_v     = sk.put;
          b_it    = sk.it;
          nmode   = sk.mode;
          nlen    = sk.len;
          line_up = sk.line_up;
          ws_fin  = sk.ws_fin;
        end
      end
      ModeQuoted: begin
        if (script_byte_i == CharQuote) begin
          a_v      = 1'b1;
          a_it     = term_it;
          a_it.ch  = CharQuote;
          a_it.has = 1'b1;
          nmode    = ModeSeek;
          nlen     = '0;
        end else if (script_byte_i >= CharSpace) begin
          a_v   = 1'b1;
          a_it  = ad.it;
          nmode = ad.end_tok ? ModeSeek : ModeQuoted;
          nlen  = ad.len;
        end else begin
          a_v     = 1'b1;
          a_it    = term_it;
          b_v     = sk.put;
          b_it    = sk.it;
          nmode   = sk.mode;
          nlen    = sk.len;
          line_up = sk.line_up;
          ws_fin  = sk.ws_fin;
        end
      end
      default: begin
        b_v     = sk.put;
        b_it    = sk.it;
        nmode   = sk.mode;
        nlen    = sk.len;
        line_up = sk.line_up;
        ws_fin  = sk.ws_fin;
      end
    endcase

    r0_it = a_v ? a_it : b_it;
    r1_it = b_it;
    n     = {1'b0, a_v} + {1'b0, b_v};
    over0 = 1'b0;
    over1 = 1'b0;
    fill  = 1'b0;

    if (is_ended) begin
      n      = 2'd1;
      r0_it  = ItemNone;
      r0_it.err = same_line_only_i ? ErrLine : ErrNone;
      over0  = 1'b1;
    end else if (final_byte_i) begin
      nmode = ModeEnded;
      nlen  = '0;
      if (n == 2'd0) begin
        n     = 2'd1;
        r0_it = ItemNone;
        fill  = 1'b1;
      end
      if (n == 2'd2) begin
        over1 = 1'b1;
        if (ws_fin && same_line_only_i) r1_it.err = ErrLine;
      end else begin
        over0 = 1'b1;
        if (ws_fin && same_line_only_i) r0_it.err = ErrLine;
      end
    end

    // an item added for the final byte shows the line after any newline it held
    nline = (line_up && state_i.line != '1) ? state_i.line + 1'b1 : state_i.line;

    state_o.mode = nmode;
    state_o.len  = nlen;
    state_o.line = nline;

    step_o.count          = n;
    step_o.r0.token_char  = r0_it.ch;
    step_o.r0.has_char    = r0_it.has;
    step_o.r0.token_done  = r0_it.done;
    step_o.r0.line_number = fill ? nline : state_i.line;
    step_o.r0.script_over = over0;
    step_o.r0.error_code  = r0_it.err;
    step_o.r0.last_of_run = (n == 2'd1);
    step_o.r1.token_char  = r1_it.ch;
    step_o.r1.has_char    = r1_it.has;
    step_o.r1.token_done  = r1_it.done;
    step_o.r1.line_number = state_i.line;
    step_o.r1.script_over = over1;
    step_o.r1.error_code  = r1_it.err;
    step_o.r1.last_of_run = 1'b1;
  end

endmodule

@@ src/sts_fifo.sv @@
module sts_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sts_pkg::step_t step_i,
  output logic           room_o,
  sts_out_if.source      out_o
);
  import sts_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  res_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      n_push;
  logic            pop;
  res_t            head;

  assign n_push = push_i ? step_i.count : 2'd0;
  assign pop    = out_o.valid && out_o.ready;
  assign room_o = cnt_q <= CntW'(FifoDepth - 2);
  assign head   = mem_q[rd_q];

  assign out_o.valid       = cnt_q != '0;
  assign out_o.token_char  = head.token_char;
  assign out_o.has_char    = head.has_char;
  assign out_o.token_done  = head.token_done;
  assign out_o.line_number = head.line_number;
  assign out_o.script_over = head.script_over;
  assign out_o.error_code  = head.error_code;
  assign out_o.last_of_run = head.last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(n_push);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= step_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= step_i.r1;
    end
  end

endmodule

@@ src/script_token_splitter.sv @@
// Streaming script tokenizer. One script byte is taken per cycle, while the result
// queue has room, into an input register; the scan state (mode, token length, line
// count) is updated from that register when the byte is taken and its result items,
// none, one or two, go into a 4-entry result queue, which hands out one item per
// cycle while the output is ready. A byte that yields two results is handed out as
// two items; the output port and its single pop per cycle set the sustained rate. A
// byte passes through the input register and the result queue to the output. After
// the final byte every further byte gives one script-over item until reset.
module script_token_splitter #(
  parameter int unsigned MaxTokenLen = sts_pkg::MaxTokenLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sts_in_if.sink    in_i,
  sts_out_if.source out_o
);
  import sts_pkg::*;

  logic       in_v_q;
  logic [7:0] byte_q;
  logic       fin_q, sl_q;
  logic       room, take;
  state_t     state_q, state_d;
  step_t      step;

  assign take       = in_v_q && room;
  assign in_i.ready = !in_v_q || take;

  sts_step #(.MaxTokenLen(MaxTokenLen)) u_step (
    .state_i         (state_q),
    .script_byte_i   (byte_q),
    .final_byte_i    (fin_q),
    .same_line_only_i(sl_q),
    .state_o         (state_d),
    .step_o          (step)
  );

  sts_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(take),
    .step_i(step),
    .room_o(room),
    .out_o (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      state_q.mode <= ModeSeek;
      state_q.len  <= '0;
      state_q.line <= LineW'(1);
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_v_q <= 1'b1;
      end else if (take) begin
        in_v_q <= 1'b0;
      end
      if (take) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.script_byte;
      fin_q  <= in_i.final_byte;
      sl_q   <= in_i.same_line_only;
    end
  end

endmodule
